### src/elvf_pkg.sv
// ----------------------------------------------------------------------------
// elvf_pkg
// Shared constants and helpers for the EGARCH log-variance filter: fixed-point
// limits, exponential constants, register indexes and reciprocal table.
// ----------------------------------------------------------------------------
package elvf_pkg;

   // Default lag orders
   localparam int DEFAULT_ARCH_ORDER  = 2;
   localparam int DEFAULT_GARCH_ORDER = 2;

   // Register file layout
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_OMEGA    = 3'd0;
   localparam logic [2:0] REG_ALPHA1   = 3'd1;
   localparam logic [2:0] REG_ALPHA2   = 3'd2;
   localparam logic [2:0] REG_GAMMA1   = 3'd3;
   localparam logic [2:0] REG_GAMMA2   = 3'd4;
   localparam logic [2:0] REG_BETA1    = 3'd5;
   localparam logic [2:0] REG_BETA2    = 3'd6;
   localparam logic [2:0] REG_BACKCAST = 3'd7;

   // Log-variance limit of +-30.0 in Q6.26
   localparam logic signed [49:0] LV_LIMIT = 50'sd2013265920;
   // E|z| = sqrt(2/pi) in Q16.16
   localparam logic [33:0] E_ABS_Z_Q16 = 34'd52290;
   // log2(e) in Q.30 and ln(2) in Q.32
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   // 1.0 in Q4.28
   localparam logic signed [32:0] ONE_Q28 = 33'sd268435456;
   // Number of Taylor terms after the constant one
   localparam logic [3:0] TERM_COUNT = 4'd12;
   // 1.0 in Q.32
   localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;

   // Clamp a wide Q6.26 value to the log-variance range
   function automatic logic signed [31:0] clamp_lv(input logic signed [49:0] v);
      logic signed [49:0] r;
      r = v;
      if (v < -LV_LIMIT) begin
         r = -LV_LIMIT;
      end else if (v > LV_LIMIT) begin
         r = LV_LIMIT;
      end
      return r[31:0];
   endfunction

   // ceil(2^32 / n) for the Taylor term divisors
   function automatic logic [32:0] rcp(input logic [3:0] n);
      logic [32:0] r;
      case (n)
         4'd1:    r = 33'd4294967296;
         4'd2:    r = 33'd2147483648;
         4'd3:    r = 33'd1431655766;
         4'd4:    r = 33'd1073741824;
         4'd5:    r = 33'd858993460;
         4'd6:    r = 33'd715827883;
         4'd7:    r = 33'd613566757;
         4'd8:    r = 33'd536870912;
         4'd9:    r = 33'd477218589;
         4'd10:   r = 33'd429496730;
         4'd11:   r = 33'd390451573;
         4'd12:   r = 33'd357913942;
         default: r = 33'd4294967296;
      endcase
      return r;
   endfunction

endpackage

### src/egarch_log_variance_filter.sv
// ----------------------------------------------------------------------------
// egarch_log_variance_filter
// EGARCH conditional log-variance and variance per residual sample, built
// around one shared 34x34 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel req_* (valid/ready) carries one residual item, Q16.16,
//    with req_series_start restarting history and warm-up.
//  - Result channel rsp_* (valid/ready) gives log-variance (Q6.26), variance
//    (Q44.20), the warm-up flag and the beta-sum flag for each item.
//  - Coefficients sit in an APB register file (csr_*); write them while idle.
//  - One item at a time: req_ready is high only while the sequencer is idle.
//    Each exponential runs twelve Taylor steps on the shared multiplier
//    (multiply, reciprocal multiply, quotient fix-up). A warm-up item needs
//    one exponential; a full item needs one per ARCH lag and one for the
//    variance, plus the lag multiply-accumulates.
//  - The result register holds an item until rsp_ready; the sequencer waits
//    in its final step while that register is still full.
//  - Reset clears configuration registers, histories and warm-up count; the first
//    max(ARCH_ORDER, GARCH_ORDER) items afterward are warm-up items.
// ----------------------------------------------------------------------------
module egarch_log_variance_filter #(
   parameter int ARCH_ORDER  = elvf_pkg::DEFAULT_ARCH_ORDER,
   parameter int GARCH_ORDER = elvf_pkg::DEFAULT_GARCH_ORDER
) (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [31:0]              req_residual,
   input  logic                            req_series_start,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_log_variance,
   output logic [63:0]                     rsp_variance_out,
   output logic                            rsp_warm_up,
   output logic                            rsp_not_stationary,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [elvf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int MAX_LAG = (ARCH_ORDER > GARCH_ORDER) ? ARCH_ORDER : GARCH_ORDER;

   // Sequencer codes
   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_LAG     = 5'd1;
   localparam logic [4:0] S_EXP_Y   = 5'd2;
   localparam logic [4:0] S_EXP_G   = 5'd3;
   localparam logic [4:0] S_EXP_GL  = 5'd4;
   localparam logic [4:0] S_T_MUL   = 5'd5;
   localparam logic [4:0] S_T_RCP   = 5'd6;
   localparam logic [4:0] S_T_Q     = 5'd7;
   localparam logic [4:0] S_T_FIX   = 5'd8;
   localparam logic [4:0] S_EXP_SH  = 5'd9;
   localparam logic [4:0] S_MAG_HI  = 5'd10;
   localparam logic [4:0] S_MAG_LO  = 5'd11;
   localparam logic [4:0] S_MAG_SUM = 5'd12;
   localparam logic [4:0] S_A_MUL   = 5'd13;
   localparam logic [4:0] S_G_MUL   = 5'd14;
   localparam logic [4:0] S_G_ACC   = 5'd15;
   localparam logic [4:0] S_B_MUL   = 5'd16;
   localparam logic [4:0] S_B_ACC   = 5'd17;
   localparam logic [4:0] S_CLAMP   = 5'd18;
   localparam logic [4:0] S_FIN     = 5'd19;

   logic [4:0]         state_ff, state_in;
   // configuration
   logic signed [31:0] omega_ff, omega_in, backcast_ff, backcast_in;
   logic signed [31:0] alpha1_ff, alpha1_in, alpha2_ff, alpha2_in;
   logic signed [31:0] gamma1_ff, gamma1_in, gamma2_ff, gamma2_in;
   logic signed [31:0] beta1_ff, beta1_in, beta2_ff, beta2_in;
   // history
   logic signed [31:0] res_hist0_ff, res_hist0_in, res_hist1_ff, res_hist1_in;
   logic signed [31:0] lv_hist0_ff, lv_hist0_in, lv_hist1_ff, lv_hist1_in;
   logic [1:0]         warm_cnt_ff, warm_cnt_in;
   // item working state
   logic signed [31:0] r_new_ff, r_new_in;
   logic               warm_ff, warm_in;
   logic               lag_ff, lag_in;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [31:0] lv_ff, lv_in;
   // exponential unit
   logic signed [32:0] x_ff, x_in;
   logic               exp_var_ff, exp_var_in;
   logic signed [9:0]  k_ff, k_in;
   logic [31:0]        g_ff, g_in;
   logic [33:0]        term_ff, term_in, sum_ff, sum_in, q_ff, q_in;
   logic [3:0]         n_ff, n_in;
   logic [32:0]        v_ff, v_in;
   logic [63:0]        exp_res_ff, exp_res_in;
   logic [63:0]        mag_ff, mag_in;
   logic [30:0]        absz_ff, absz_in;
   // shared multiplier
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff, prod_in;
   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_lv_ff, rsp_lv_in;
   logic [63:0]        rsp_var_ff, rsp_var_in;
   logic               rsp_warm_ff, rsp_warm_in, rsp_ns_ff, rsp_ns_in;

   // lag selection and helpers
   logic signed [31:0] lh_sel, r_sel, alpha_sel, gamma_sel, beta_sel;
   logic signed [32:0] neg_lh, r_ext, abs_r33;
   logic [63:0]        mag_sum;
   logic [33:0]        z_mag;
   logic [37:0]        qn;
   logic signed [10:0] shift_s, shift_neg;
   logic [97:0]        shl_wide;
   logic [63:0]        exp_out;
   logic signed [32:0] beta_sum;
   logic [1:0]         cnt_eff;
   logic               accept, cfg_wr;

   assign accept    = req_valid && req_ready;
   assign cfg_wr    = csr_psel && csr_penable && csr_pwrite;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_pready = 1'b1;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_log_variance   = rsp_lv_ff;
   assign rsp_variance_out   = rsp_var_ff;
   assign rsp_warm_up        = rsp_warm_ff;
   assign rsp_not_stationary = rsp_ns_ff;

   // Pick the operands of the current lag
   assign lh_sel    = lag_ff ? lv_hist1_ff  : lv_hist0_ff;
   assign r_sel     = lag_ff ? res_hist1_ff : res_hist0_ff;
   assign alpha_sel = lag_ff ? alpha2_ff    : alpha1_ff;
   assign gamma_sel = lag_ff ? gamma2_ff    : gamma1_ff;
   assign beta_sel  = lag_ff ? beta2_ff     : beta1_ff;

   assign neg_lh  = -{lh_sel[31], lh_sel};
   assign r_ext   = {r_sel[31], r_sel};
   assign abs_r33 = r_sel[31] ? -r_ext : r_ext;
   assign mag_sum = mag_ff + {32'b0, prod_ff[63:32]};
   assign z_mag   = r_sel[31] ? -{3'b000, absz_ff} : {3'b000, absz_ff};
   assign qn      = 38'(q_ff) * 38'(n_ff);

   // Final scaling of the Taylor sum by 2^(k + frac - 32)
   assign shift_s   = {k_ff[9], k_ff} + (exp_var_ff ? -11'sd12 : 11'sd0);
   assign shift_neg = -shift_s;
   assign shl_wide  = {64'b0, sum_ff} << shift_s[5:0];
   always_comb begin
      if (!shift_s[10]) begin
         if (shift_s >= 11'sd64 || (|shl_wide[97:64])) begin
            exp_out = '1;
         end else begin
            exp_out = shl_wide[63:0];
         end
      end else if (shift_neg >= 11'sd64) begin
         exp_out = '0;
      end else begin
         exp_out = 64'({30'b0, sum_ff} >> shift_neg[5:0]);
      end
   end

   assign beta_sum = {beta1_ff[31], beta1_ff} +
                     ((GARCH_ORDER > 1) ? {beta2_ff[31], beta2_ff} : 33'sd0);
   assign cnt_eff  = req_series_start ? 2'd0 : warm_cnt_ff;

   // Register read
   always_comb begin
      case (csr_paddr[4:2])
         elvf_pkg::REG_OMEGA:    csr_prdata = omega_ff;
         elvf_pkg::REG_ALPHA1:   csr_prdata = alpha1_ff;
         elvf_pkg::REG_ALPHA2:   csr_prdata = alpha2_ff;
         elvf_pkg::REG_GAMMA1:   csr_prdata = gamma1_ff;
         elvf_pkg::REG_GAMMA2:   csr_prdata = gamma2_ff;
         elvf_pkg::REG_BETA1:    csr_prdata = beta1_ff;
         elvf_pkg::REG_BETA2:    csr_prdata = beta2_ff;
         elvf_pkg::REG_BACKCAST: csr_prdata = backcast_ff;
         default:                csr_prdata = '0;
      endcase
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      omega_in     = omega_ff;
      alpha1_in    = alpha1_ff;
      alpha2_in    = alpha2_ff;
      gamma1_in    = gamma1_ff;
      gamma2_in    = gamma2_ff;
      beta1_in     = beta1_ff;
      beta2_in     = beta2_ff;
      backcast_in  = backcast_ff;
      res_hist0_in = res_hist0_ff;
      res_hist1_in = res_hist1_ff;
      lv_hist0_in  = lv_hist0_ff;
      lv_hist1_in  = lv_hist1_ff;
      warm_cnt_in  = warm_cnt_ff;
      r_new_in     = r_new_ff;
      warm_in      = warm_ff;
      lag_in       = lag_ff;
      acc_in       = acc_ff;
      lv_in        = lv_ff;
      x_in         = x_ff;
      exp_var_in   = exp_var_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      v_in         = v_ff;
      exp_res_in   = exp_res_ff;
      mag_in       = mag_ff;
      absz_in      = absz_ff;
      mul_a        = '0;
      mul_b        = '0;
      rsp_lv_in    = rsp_lv_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_warm_in  = rsp_warm_ff;
      rsp_ns_in    = rsp_ns_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Write configuration registers
      if (cfg_wr) begin
         case (csr_paddr[4:2])
            elvf_pkg::REG_OMEGA:    omega_in    = csr_pwdata;
            elvf_pkg::REG_ALPHA1:   alpha1_in   = csr_pwdata;
            elvf_pkg::REG_ALPHA2:   alpha2_in   = csr_pwdata;
            elvf_pkg::REG_GAMMA1:   gamma1_in   = csr_pwdata;
            elvf_pkg::REG_GAMMA2:   gamma2_in   = csr_pwdata;
            elvf_pkg::REG_BETA1:    beta1_in    = csr_pwdata;
            elvf_pkg::REG_BETA2:    beta2_in    = csr_pwdata;
            elvf_pkg::REG_BACKCAST: backcast_in = csr_pwdata;
            default:                omega_in    = omega_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            // Take an item, restart the series if asked, pick warm-up or recursion
            if (accept) begin
               r_new_in = req_residual;
               if (req_series_start) begin
                  res_hist0_in = '0;
                  res_hist1_in = '0;
                  lv_hist0_in  = '0;
                  lv_hist1_in  = '0;
               end
               lag_in = 1'b0;
               if (int'(cnt_eff) < MAX_LAG) begin
                  warm_in     = 1'b1;
                  warm_cnt_in = cnt_eff + 2'd1;
                  lv_in       = elvf_pkg::clamp_lv({{18{backcast_ff[31]}}, backcast_ff});
                  x_in        = {lv_in[31], lv_in};
                  exp_var_in  = 1'b1;
                  state_in    = S_EXP_Y;
               end else begin
                  warm_in     = 1'b0;
                  warm_cnt_in = cnt_eff;
                  acc_in      = {{18{omega_ff[31]}}, omega_ff};
                  state_in    = S_LAG;
               end
            end
         end
         S_LAG: begin
            // Scale exponent is floor(-L/2)
            x_in       = neg_lh >>> 1;
            exp_var_in = 1'b0;
            state_in   = S_EXP_Y;
         end
         S_EXP_Y: begin
            mul_a    = {x_ff[32], x_ff};
            mul_b    = {3'b000, elvf_pkg::LOG2E_Q30};
            state_in = S_EXP_G;
         end
         S_EXP_G: begin
            // Split y into integer k and fraction f, then g = f * ln2
            k_in     = prod_ff[65:56];
            mul_a    = {8'b0, prod_ff[55:30]};
            mul_b    = {2'b00, elvf_pkg::LN2_Q32};
            state_in = S_EXP_GL;
         end
         S_EXP_GL: begin
            g_in     = prod_ff[57:26];
            term_in  = elvf_pkg::ONE_Q32;
            sum_in   = elvf_pkg::ONE_Q32;
            n_in     = 4'd1;
            state_in = S_T_MUL;
         end
         S_T_MUL: begin
            mul_a    = $signed(term_ff);
            mul_b    = {2'b00, g_ff};
            state_in = S_T_RCP;
         end
         S_T_RCP: begin
            // Divide by n through its reciprocal
            v_in     = prod_ff[64:32];
            mul_a    = {1'b0, prod_ff[64:32]};
            mul_b    = {1'b0, elvf_pkg::rcp(n_ff)};
            state_in = S_T_Q;
         end
         S_T_Q: begin
            q_in     = prod_ff[65:32];
            state_in = S_T_FIX;
         end
         S_T_FIX: begin
            // Step the quotient down until q*n fits, then add the term
            if (qn > {5'b0, v_ff}) begin
               q_in = q_ff - 34'd1;
            end else begin
               term_in = q_ff;
               sum_in  = sum_ff + q_ff;
               if (n_ff == elvf_pkg::TERM_COUNT) begin
                  state_in = S_EXP_SH;
               end else begin
                  n_in     = n_ff + 4'd1;
                  state_in = S_T_MUL;
               end
            end
         end
         S_EXP_SH: begin
            exp_res_in = exp_out;
            state_in   = exp_var_ff ? S_FIN : S_MAG_HI;
         end
         S_MAG_HI: begin
            mul_a    = {2'b00, abs_r33[31:0]};
            mul_b    = {2'b00, exp_res_ff[63:32]};
            state_in = S_MAG_LO;
         end
         S_MAG_LO: begin
            mag_in   = prod_ff[63:0];
            mul_a    = {2'b00, abs_r33[31:0]};
            mul_b    = {2'b00, exp_res_ff[31:0]};
            state_in = S_MAG_SUM;
         end
         S_MAG_SUM: begin
            // Saturate |z|
            absz_in  = (mag_sum > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : mag_sum[30:0];
            state_in = S_A_MUL;
         end
         S_A_MUL: begin
            mul_a    = {{2{alpha_sel[31]}}, alpha_sel};
            mul_b    = $signed({3'b000, absz_ff} - elvf_pkg::E_ABS_Z_Q16);
            state_in = S_G_MUL;
         end
         S_G_MUL: begin
            acc_in   = acc_ff + 50'(prod_ff >>> 18);
            mul_a    = {{2{gamma_sel[31]}}, gamma_sel};
            mul_b    = $signed(z_mag);
            state_in = S_G_ACC;
         end
         S_G_ACC: begin
            acc_in = acc_ff + 50'(prod_ff >>> 18);
            if (int'(lag_ff) + 1 < ARCH_ORDER) begin
               lag_in   = 1'b1;
               state_in = S_LAG;
            end else begin
               lag_in   = 1'b0;
               state_in = S_B_MUL;
            end
         end
         S_B_MUL: begin
            mul_a    = {{2{beta_sel[31]}}, beta_sel};
            mul_b    = {{2{lh_sel[31]}}, lh_sel};
            state_in = S_B_ACC;
         end
         S_B_ACC: begin
            acc_in = acc_ff + 50'(prod_ff >>> 28);
            if (int'(lag_ff) + 1 < GARCH_ORDER) begin
               lag_in   = 1'b1;
               state_in = S_B_MUL;
            end else begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            lv_in      = elvf_pkg::clamp_lv(acc_ff);
            x_in       = {lv_in[31], lv_in};
            exp_var_in = 1'b1;
            state_in   = S_EXP_Y;
         end
         S_FIN: begin
            // Hand the item to the result register and advance history
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_lv_in    = lv_ff;
               rsp_var_in   = exp_res_ff;
               rsp_warm_in  = warm_ff;
               rsp_ns_in    = (beta_sum >= elvf_pkg::ONE_Q28);
               res_hist1_in = res_hist0_ff;
               res_hist0_in = r_new_ff;
               lv_hist1_in  = lv_hist0_ff;
               lv_hist0_in  = lv_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         omega_ff     <= '0;
         alpha1_ff    <= '0;
         alpha2_ff    <= '0;
         gamma1_ff    <= '0;
         gamma2_ff    <= '0;
         beta1_ff     <= '0;
         beta2_ff     <= '0;
         backcast_ff  <= '0;
         res_hist0_ff <= '0;
         res_hist1_ff <= '0;
         lv_hist0_ff  <= '0;
         lv_hist1_ff  <= '0;
         warm_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         omega_ff     <= omega_in;
         alpha1_ff    <= alpha1_in;
         alpha2_ff    <= alpha2_in;
         gamma1_ff    <= gamma1_in;
         gamma2_ff    <= gamma2_in;
         beta1_ff     <= beta1_in;
         beta2_ff     <= beta2_in;
         backcast_ff  <= backcast_in;
         res_hist0_ff <= res_hist0_in;
         res_hist1_ff <= res_hist1_in;
         lv_hist0_ff  <= lv_hist0_in;
         lv_hist1_ff  <= lv_hist1_in;
         warm_cnt_ff  <= warm_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      r_new_ff   <= r_new_in;
      warm_ff    <= warm_in;
      lag_ff     <= lag_in;
      acc_ff     <= acc_in;
      lv_ff      <= lv_in;
      x_ff       <= x_in;
      exp_var_ff <= exp_var_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      term_ff    <= term_in;
      sum_ff     <= sum_in;
      q_ff       <= q_in;
      n_ff       <= n_in;
      v_ff       <= v_in;
      exp_res_ff <= exp_res_in;
      mag_ff     <= mag_in;
      absz_ff    <= absz_in;
      prod_ff    <= prod_in;
      rsp_lv_ff  <= rsp_lv_in;
      rsp_var_ff <= rsp_var_in;
      rsp_warm_ff <= rsp_warm_in;
      rsp_ns_ff  <= rsp_ns_in;
   end

   // Assertions
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after taking an item");

   a_lv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_lv_ff <= 32'sd2013265920 && rsp_lv_ff >= -32'sd2013265920))
      else $error("log-variance result out of range");

   a_warm_cnt: assert property (@(posedge clock) disable iff (reset)
      int'(warm_cnt_ff) <= MAX_LAG)
      else $error("warm-up count past the lag depth");

   a_term_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T_MUL || state_ff == S_T_RCP || state_ff == S_T_Q ||
       state_ff == S_T_FIX) |-> (n_ff >= 4'd1 && n_ff <= elvf_pkg::TERM_COUNT))
      else $error("Taylor term index out of range");

endmodule
